// ===== rtl/i2c_write_master_scl_mux_top_macros.svh =====
// Assertion macros for the I2C write master with clock line select.
// Used by the top level; no other dependencies.
`ifndef I2C_WRITE_MASTER_SCL_MUX_TOP_MACROS_SVH
`define I2C_WRITE_MASTER_SCL_MUX_TOP_MACROS_SVH

// same-cycle implication under reset
`define I2CWM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("i2cwm assertion failed");

// next-cycle implication under reset
`define I2CWM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("i2cwm assertion failed");

`endif

// ===== rtl/i2cwm_pkg.sv =====
// Shared types and constants of the I2C write master with clock line select.
// No dependencies.
package i2cwm_pkg;

    localparam int CLOCK_LINES_DEFAULT = 4;
    localparam int SCL_PORT_W          = 4;
    localparam int QUEUE_DEPTH         = 2;
    localparam int PHASE_W             = 6;
    localparam int START_PHASES        = 3;
    localparam int STOP_PHASES         = 3;
    localparam int BYTE_PHASES         = 35;
    localparam int ACK_FIRST           = 32;

    localparam logic [1:0] CMD_START  = 2'd0;
    localparam logic [1:0] CMD_BYTE   = 2'd1;
    localparam logic [1:0] CMD_STOP   = 2'd2;
    localparam logic [1:0] CMD_SELECT = 2'd3;

    typedef enum logic [1:0] {
        KIND_START,
        KIND_BYTE,
        KIND_STOP,
        KIND_SELECT
    } kind_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
        logic       line_ok;
    } desc_t;

endpackage

// ===== rtl/i2cwm_if.sv =====
// Handshake channels of the I2C write master: command items and phase items.
// Depends on nothing.
interface i2cwm_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] cmd;
    logic [6:0] target_address;
    logic [7:0] payload_byte;
    logic [7:0] line_choice;

    modport source (output valid, output cmd, output target_address,
                    output payload_byte, output line_choice, input ready);
    modport sink   (input valid, input cmd, input target_address,
                    input payload_byte, input line_choice, output ready);
endinterface

interface i2cwm_phase_if;
    logic       valid;
    logic       ready;
    logic       sda_level;
    logic [3:0] scl_levels;
    logic       ack_sample;
    logic       last;

    modport source (output valid, output sda_level, output scl_levels,
                    output ack_sample, output last, input ready);
    modport sink   (input valid, input sda_level, input scl_levels,
                    input ack_sample, input last, output ready);
endinterface

// ===== rtl/i2cwm_front.sv =====
// Front stage: accepts command items and classifies them into descriptors.
// Depends on i2cwm_pkg and i2cwm_cmd_if.
module i2cwm_front #(
    parameter int CLOCK_LINES = i2cwm_pkg::CLOCK_LINES_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    i2cwm_cmd_if.sink          cmd_chan,
    output logic               desc_valid,
    input  logic               desc_ready,
    output i2cwm_pkg::desc_t   desc
);

    logic             valid_reg;
    logic             valid_next;
    i2cwm_pkg::desc_t desc_reg;
    i2cwm_pkg::desc_t desc_next;
    logic             take;

    assign cmd_chan.ready = !valid_reg || desc_ready;
    assign take           = cmd_chan.valid && cmd_chan.ready;
    assign desc_valid     = valid_reg;
    assign desc           = desc_reg;

    always_comb
    begin
        desc_next         = desc_reg;
        desc_next.line_ok = (cmd_chan.line_choice != 8'd0) &&
                            (cmd_chan.line_choice <= 8'(CLOCK_LINES));
        case (cmd_chan.cmd)
            i2cwm_pkg::CMD_START:
            begin
                desc_next.kind = i2cwm_pkg::KIND_START;
                desc_next.data = {cmd_chan.target_address, 1'b0};
            end
            i2cwm_pkg::CMD_BYTE:
            begin
                desc_next.kind = i2cwm_pkg::KIND_BYTE;
                desc_next.data = cmd_chan.payload_byte;
            end
            i2cwm_pkg::CMD_STOP:
            begin
                desc_next.kind = i2cwm_pkg::KIND_STOP;
                desc_next.data = 8'd0;
            end
            default:
            begin
                desc_next.kind = i2cwm_pkg::KIND_SELECT;
                desc_next.data = cmd_chan.line_choice;
            end
        endcase
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (desc_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            desc_reg <= desc_next;
        end
    end

endmodule

// ===== rtl/i2cwm_queue.sv =====
// Short descriptor queue between the front stage and the phase sequencer.
// Depends on i2cwm_pkg.
module i2cwm_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  i2cwm_pkg::desc_t push_desc,
    output logic             pop_valid,
    input  logic             pop_ready,
    output i2cwm_pkg::desc_t pop_desc
);

    localparam int DEPTH = i2cwm_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    i2cwm_pkg::desc_t mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             push;
    logic             pop;

    assign push_ready = count_reg != CNT_W'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_desc   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_desc;
        end
    end

endmodule

// ===== rtl/i2cwm_back.sv =====
// Phase sequencer: walks each descriptor through its bus phases, holds the
// pin state and the selected clock line. Depends on i2cwm_pkg, i2cwm_phase_if.
module i2cwm_back #(
    parameter int CLOCK_LINES = i2cwm_pkg::CLOCK_LINES_DEFAULT
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             desc_valid,
    output logic             desc_ready,
    input  i2cwm_pkg::desc_t desc,
    i2cwm_phase_if.source    phase_chan
);

    localparam int LINE_W = (CLOCK_LINES > 1) ? $clog2(CLOCK_LINES) : 1;
    localparam int PW     = i2cwm_pkg::PHASE_W;

    logic                   busy_reg;
    logic                   busy_next;
    i2cwm_pkg::desc_t       cur_reg;
    i2cwm_pkg::desc_t       cur_next;
    logic [PW-1:0]          phase_reg;
    logic [PW-1:0]          phase_next;
    logic [CLOCK_LINES-1:0] scl_reg;
    logic [CLOCK_LINES-1:0] scl_next;
    logic                   sda_reg;
    logic                   sda_next;
    logic [LINE_W-1:0]      line_reg;
    logic [LINE_W-1:0]      line_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic                   out_sda_reg;
    logic [3:0]             out_scl_reg;
    logic [3:0]             out_scl_next;
    logic                   out_ack_reg;
    logic                   out_last_reg;

    logic                   emit;
    logic                   pop;
    logic [PW-1:0]          bp;
    logic                   bit_val;
    logic                   in_byte;
    logic                   drive_low;
    logic                   drive_high;
    logic                   sda_load;
    logic                   sda_val;
    logic                   ack;
    logic                   fin;
    logic [CLOCK_LINES-1:0] mask;
    logic [CLOCK_LINES-1:0] scl_new;
    logic                   sda_new;

    assign emit       = busy_reg && (!out_valid_reg || phase_chan.ready);
    assign pop        = desc_valid && (!busy_reg || (emit && fin));
    assign desc_ready = !busy_reg || (emit && fin);

    assign bp      = (cur_reg.kind == i2cwm_pkg::KIND_START) ?
                     phase_reg - PW'(i2cwm_pkg::START_PHASES) : phase_reg;
    assign bit_val = cur_reg.data[~bp[4:2]];
    assign in_byte = (cur_reg.kind == i2cwm_pkg::KIND_BYTE) ||
                     ((cur_reg.kind == i2cwm_pkg::KIND_START) &&
                      (phase_reg >= PW'(i2cwm_pkg::START_PHASES)));

    always_comb
    begin
        drive_low  = 1'b0;
        drive_high = 1'b0;
        sda_load   = 1'b0;
        sda_val    = 1'b1;
        ack        = 1'b0;
        fin        = 1'b0;
        case (cur_reg.kind)
            i2cwm_pkg::KIND_STOP:
            begin
                fin = phase_reg == PW'(i2cwm_pkg::STOP_PHASES - 1);
                case (phase_reg[1:0])
                    2'd0:
                    begin
                        drive_low = 1'b1;
                        sda_load  = 1'b1;
                        sda_val   = 1'b0;
                    end
                    2'd1:    drive_high = 1'b1;
                    default: sda_load   = 1'b1;
                endcase
            end
            i2cwm_pkg::KIND_SELECT:
            begin
                drive_low = 1'b1;
                fin       = 1'b1;
            end
            default:
            begin
                if (!in_byte)
                begin
                    case (phase_reg[1:0])
                        2'd0:
                        begin
                            drive_high = 1'b1;
                            sda_load   = 1'b1;
                        end
                        2'd1:
                        begin
                            sda_load = 1'b1;
                            sda_val  = 1'b0;
                        end
                        default: drive_low = 1'b1;
                    endcase
                end
                else if (bp < PW'(i2cwm_pkg::ACK_FIRST))
                begin
                    case (bp[1:0])
                        2'd1:
                        begin
                            sda_load = 1'b1;
                            sda_val  = bit_val;
                        end
                        2'd2:    drive_high = 1'b1;
                        default: drive_low  = 1'b1;
                    endcase
                end
                else
                begin
                    fin = bp == PW'(i2cwm_pkg::BYTE_PHASES - 1);
                    if (bp == PW'(i2cwm_pkg::ACK_FIRST))
                    begin
                        drive_low = 1'b1;
                        sda_load  = 1'b1;
                    end
                    else if (bp == PW'(i2cwm_pkg::ACK_FIRST + 1))
                    begin
                        drive_high = 1'b1;
                        ack        = 1'b1;
                    end
                    else
                    begin
                        drive_low = 1'b1;
                    end
                end
            end
        endcase
    end

    always_comb
    begin
        mask           = '0;
        mask[line_reg] = 1'b1;
        scl_new        = scl_reg;
        if (drive_low)
        begin
            scl_new = scl_reg & ~mask;
        end
        else if (drive_high)
        begin
            scl_new = scl_reg | mask;
        end
        sda_new = sda_load ? sda_val : sda_reg;
    end

    generate
        for (genvar i = 0; i < 4; i++)
        begin : g_scl_out
            if (i < CLOCK_LINES)
            begin : g_used
                assign out_scl_next[i] = scl_new[i];
            end
            else
            begin : g_unused
                assign out_scl_next[i] = 1'b0;
            end
        end
    endgenerate

    always_comb
    begin
        busy_next      = busy_reg;
        cur_next       = cur_reg;
        phase_next     = phase_reg;
        scl_next       = scl_reg;
        sda_next       = sda_reg;
        line_next      = line_reg;
        out_valid_next = out_valid_reg;
        if (phase_chan.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (emit)
        begin
            out_valid_next = 1'b1;
            scl_next       = scl_new;
            sda_next       = sda_new;
            phase_next     = phase_reg + 1'b1;
            if ((cur_reg.kind == i2cwm_pkg::KIND_SELECT) && cur_reg.line_ok)
            begin
                line_next = LINE_W'(cur_reg.data - 8'd1);
            end
            if (fin)
            begin
                busy_next = 1'b0;
            end
        end
        if (pop)
        begin
            busy_next  = 1'b1;
            cur_next   = desc;
            phase_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            phase_reg     <= '0;
            scl_reg       <= '1;
            sda_reg       <= 1'b1;
            line_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            phase_reg     <= phase_next;
            scl_reg       <= scl_next;
            sda_reg       <= sda_next;
            line_reg      <= line_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        if (emit)
        begin
            out_sda_reg  <= sda_new;
            out_scl_reg  <= out_scl_next;
            out_ack_reg  <= ack;
            out_last_reg <= fin;
        end
    end

    assign phase_chan.valid      = out_valid_reg;
    assign phase_chan.sda_level  = out_sda_reg;
    assign phase_chan.scl_levels = out_scl_reg;
    assign phase_chan.ack_sample = out_ack_reg;
    assign phase_chan.last       = out_last_reg;

endmodule

// ===== rtl/i2c_write_master_scl_mux_top.sv =====
// Path: front register, queue, descriptor register, then the phase output register.
// Throughput: one phase item per cycle from the phase sequencer while phase_chan is
// ready; phases per command: 38 start+address, 35 byte, 3 stop, 1 select.
// Commands are taken back to back while the two-entry queue has room.
// Reset (async, active low): all clock lines and SDA released, line 1 selected.
module i2c_write_master_scl_mux_top #(
    parameter int CLOCK_LINES = i2cwm_pkg::CLOCK_LINES_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    i2cwm_cmd_if.sink     cmd_chan,
    i2cwm_phase_if.source phase_chan
);

`include "i2c_write_master_scl_mux_top_macros.svh"

    logic             f_valid;
    logic             f_ready;
    i2cwm_pkg::desc_t f_desc;
    logic             q_valid;
    logic             q_ready;
    i2cwm_pkg::desc_t q_desc;

    i2cwm_front #(
        .CLOCK_LINES (CLOCK_LINES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_chan   (cmd_chan),
        .desc_valid (f_valid),
        .desc_ready (f_ready),
        .desc       (f_desc)
    );

    i2cwm_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_desc  (f_desc),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_desc   (q_desc)
    );

    i2cwm_back #(
        .CLOCK_LINES (CLOCK_LINES)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .desc_valid (q_valid),
        .desc_ready (q_ready),
        .desc       (q_desc),
        .phase_chan (phase_chan)
    );

    `I2CWM_ASSERT_NOW(a_ack_released, clk, rst_n, phase_chan.valid && phase_chan.ack_sample, phase_chan.sda_level && !phase_chan.last)
    `I2CWM_ASSERT_NEXT(a_front_loaded, clk, rst_n, cmd_chan.valid && cmd_chan.ready, f_valid)
    `I2CWM_ASSERT_NEXT(a_front_holds, clk, rst_n, f_valid && !f_ready, f_valid && $stable(f_desc))

endmodule

// ===== tb/sv/i2c_write_master_scl_mux_top_tb.sv =====
// Testbench for i2c_write_master_scl_mux_top: sends command items and checks every phase
// item against an in-bench model of the bus levels, under several idle and stall patterns.
// Depends on i2cwm_pkg, the i2cwm_cmd_if / i2cwm_phase_if interfaces and the top level.
module i2c_write_master_scl_mux_top_tb;

    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES = 20;

    typedef struct packed {
        logic       sda;
        logic [3:0] scl;
        logic       ack;
        logic       last;
    } phase_t;

    logic clk;
    logic rst_n;

    i2cwm_cmd_if   cmd_chan ();
    i2cwm_phase_if phase_chan ();

    i2c_write_master_scl_mux_top i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_chan   (cmd_chan),
        .phase_chan (phase_chan)
    );

    phase_t     bus_phase_q[$];
    logic [2:0] sel_line;
    logic [3:0] scl_state;
    logic       sda_state;
    int         mismatches = 0;
    int         send_idle_pct = 0;
    int         stall_pct = 0;
    logic       burst_req = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

    // bus model
    function automatic void drive_scl(input logic level);
        logic [3:0] sel;
        sel = 4'b0001 << (sel_line - 3'd1);
        if (level)
            scl_state = scl_state | sel;
        else
            scl_state = scl_state & ~sel;
    endfunction

    function automatic void record_phase(input logic ack, input logic last);
        phase_t p;
        p.sda  = sda_state;
        p.scl  = scl_state;
        p.ack  = ack;
        p.last = last;
        bus_phase_q.push_back(p);
    endfunction

    function automatic void shift_out_byte(input logic [7:0] value);
        for (int k = 7; k >= 0; k--)
        begin
            drive_scl(1'b0);
            record_phase(1'b0, 1'b0);
            sda_state = value[k];
            record_phase(1'b0, 1'b0);
            drive_scl(1'b1);
            record_phase(1'b0, 1'b0);
            drive_scl(1'b0);
            record_phase(1'b0, 1'b0);
        end
        sda_state = 1'b1;
        drive_scl(1'b0);
        record_phase(1'b0, 1'b0);
        drive_scl(1'b1);
        record_phase(1'b1, 1'b0);
        drive_scl(1'b0);
        record_phase(1'b0, 1'b1);
    endfunction

    function automatic void predict_bus_phases(input logic [1:0] cmd, input logic [6:0] addr,
                                               input logic [7:0] data, input logic [7:0] line);
        case (cmd)
            i2cwm_pkg::CMD_START:
            begin
                drive_scl(1'b1);
                sda_state = 1'b1;
                record_phase(1'b0, 1'b0);
                sda_state = 1'b0;
                record_phase(1'b0, 1'b0);
                drive_scl(1'b0);
                record_phase(1'b0, 1'b0);
                shift_out_byte({addr, 1'b0});
            end
            i2cwm_pkg::CMD_BYTE:
            begin
                shift_out_byte(data);
            end
            i2cwm_pkg::CMD_STOP:
            begin
                drive_scl(1'b0);
                sda_state = 1'b0;
                record_phase(1'b0, 1'b0);
                drive_scl(1'b1);
                record_phase(1'b0, 1'b0);
                sda_state = 1'b1;
                record_phase(1'b0, 1'b1);
            end
            default:
            begin
                drive_scl(1'b0);
                if (line >= 8'd1 && line <= i2cwm_pkg::CLOCK_LINES_DEFAULT)
                    sel_line = line[2:0];
                record_phase(1'b0, 1'b1);
            end
        endcase
    endfunction

    task automatic send_cmd(input logic [1:0] cmd, input logic [6:0] addr,
                            input logic [7:0] data, input logic [7:0] line);
        while ($urandom_range(99) < send_idle_pct)
        begin
            cmd_chan.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_chan.valid          <= 1'b1;
        cmd_chan.cmd            <= cmd;
        cmd_chan.target_address <= addr;
        cmd_chan.payload_byte   <= data;
        cmd_chan.line_choice    <= line;
        do
            @(posedge clk);
        while (!cmd_chan.ready);
        predict_bus_phases(cmd, addr, data, line);
    endtask

    task automatic send_frame(input int bytes);
        send_cmd(i2cwm_pkg::CMD_START, 7'($urandom_range(127)), 8'($urandom_range(255)),
                 8'($urandom_range(255)));
        for (int i = 0; i < bytes; i++)
            send_cmd(i2cwm_pkg::CMD_BYTE, 7'($urandom_range(127)), 8'($urandom_range(255)),
                     8'($urandom_range(255)));
        send_cmd(i2cwm_pkg::CMD_STOP, 7'($urandom_range(127)), 8'($urandom_range(255)),
                 8'($urandom_range(255)));
    endtask

    task automatic test_directed_frames();
        send_idle_pct = 0;
        stall_pct     <= 0;
        send_cmd(i2cwm_pkg::CMD_START, 7'd0, 8'hFF, 8'hFF);
        send_cmd(i2cwm_pkg::CMD_BYTE, 7'h7F, 8'h00, 8'hFF);
        send_cmd(i2cwm_pkg::CMD_BYTE, 7'h00, 8'hFF, 8'h00);
        send_cmd(i2cwm_pkg::CMD_STOP, 7'h7F, 8'hFF, 8'hFF);
        send_cmd(i2cwm_pkg::CMD_START, 7'h7F, 8'h00, 8'h00);
        send_cmd(i2cwm_pkg::CMD_BYTE, 7'h00, 8'hA5, 8'h02);
        send_cmd(i2cwm_pkg::CMD_STOP, 7'h00, 8'h00, 8'h00);
        send_cmd(i2cwm_pkg::CMD_BYTE, 7'h55, 8'h5A, 8'h04);
        send_cmd(i2cwm_pkg::CMD_STOP, 7'h2A, 8'h80, 8'h01);
    endtask

    task automatic test_line_select();
        send_cmd(i2cwm_pkg::CMD_SELECT, 7'h7F, 8'hFF, 8'd4);
        send_cmd(i2cwm_pkg::CMD_SELECT, 7'h00, 8'h00, 8'd0);
        send_cmd(i2cwm_pkg::CMD_SELECT, 7'h7F, 8'hFF, 8'd5);
        send_cmd(i2cwm_pkg::CMD_SELECT, 7'h00, 8'h00, 8'd255);
        send_cmd(i2cwm_pkg::CMD_SELECT, 7'h12, 8'h34, 8'd3);
        send_cmd(i2cwm_pkg::CMD_START, 7'h55, 8'h00, 8'd1);
        send_cmd(i2cwm_pkg::CMD_BYTE, 7'h00, 8'h01, 8'd2);
        send_cmd(i2cwm_pkg::CMD_STOP, 7'h00, 8'h00, 8'd4);
        send_cmd(i2cwm_pkg::CMD_SELECT, 7'h00, 8'h00, 8'd2);
        send_cmd(i2cwm_pkg::CMD_SELECT, 7'h00, 8'h00, 8'd1);
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        stall_pct     <= 0;
        burst_req     <= ~burst_req;
        send_frame(4);
    endtask

    task automatic test_random_traffic(input int idle_pct, input int hold_pct, input int items);
        int sent;
        int pick;
        int bytes;
        logic [7:0] line;
        send_idle_pct = idle_pct;
        stall_pct     <= hold_pct;
        sent          = 0;
        while (sent < items)
        begin
            pick = $urandom_range(9);
            if (pick < 7)
            begin
                bytes = $urandom_range(3, 1);
                send_frame(bytes);
                sent += bytes + 2;
            end
            else if (pick == 7)
            begin
                line = $urandom_range(1) ? 8'($urandom_range(4, 1)) : 8'($urandom_range(255));
                send_cmd(i2cwm_pkg::CMD_SELECT, 7'($urandom_range(127)),
                         8'($urandom_range(255)), line);
                sent++;
            end
            else
            begin
                send_cmd(2'($urandom_range(3)), 7'($urandom_range(127)),
                         8'($urandom_range(255)), 8'($urandom_range(255)));
                sent++;
            end
        end
    endtask

    initial
    begin : ready_drive
        int   hold_left;
        logic burst_seen;
        hold_left  = 0;
        burst_seen = 1'b0;
        phase_chan.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (burst_req != burst_seen)
            begin
                burst_seen = burst_req;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                phase_chan.ready <= 1'b0;
            end
            else
                phase_chan.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    initial
    begin : phase_check
        phase_t got;
        phase_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && phase_chan.valid && phase_chan.ready)
            begin
                got.sda  = phase_chan.sda_level;
                got.scl  = phase_chan.scl_levels;
                got.ack  = phase_chan.ack_sample;
                got.last = phase_chan.last;
                if (bus_phase_q.size() == 0)
                begin
                    $display("%0t: unexpected phase item sda=%b scl=%b ack=%b last=%b",
                             $time, got.sda, got.scl, got.ack, got.last);
                    mismatches++;
                end
                else
                begin
                    want = bus_phase_q.pop_front();
                    if (got.sda !== want.sda || got.scl !== want.scl ||
                        got.ack !== want.ack || got.last !== want.last)
                    begin
                        $display({"%0t: expected sda=%b scl=%b ack=%b last=%b,",
                                  " got sda=%b scl=%b ack=%b last=%b"},
                                 $time, want.sda, want.scl, want.ack, want.last,
                                 got.sda, got.scl, got.ack, got.last);
                        mismatches++;
                    end
                end
            end
        end
    end

    initial
    begin
        sel_line  = 3'd1;
        scl_state = 4'hF;
        sda_state = 1'b1;
        rst_n     = 1'b0;
        cmd_chan.valid          <= 1'b0;
        cmd_chan.cmd            <= i2cwm_pkg::CMD_START;
        cmd_chan.target_address <= 7'd0;
        cmd_chan.payload_byte   <= 8'd0;
        cmd_chan.line_choice    <= 8'd0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_frames();
        test_line_select();
        test_backpressure();
        test_random_traffic(0, 0, 20);
        test_random_traffic(78, 0, 20);
        test_random_traffic(0, 78, 20);
        test_random_traffic(28, 28, 20);

        cmd_chan.valid <= 1'b0;
        while (bus_phase_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && bus_phase_q.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
